FILE: sv/gvc_pkg.sv
package gvc_pkg;

    localparam int PHASE_BINS     = 8;
    localparam int BIN_W          = 3;
    localparam int VOTE_W         = 24;
    localparam int SAMPLE_W       = 8;
    localparam int DIFF_W         = 9;
    localparam int ROW_W          = 12;
    localparam int HEIGHT_W       = 13;
    localparam int WIDTH_REG_W    = 12;
    localparam int WIN_COL_W      = 11;
    localparam int WIN_ROW_W      = 12;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 13;
    localparam int MAX_HEIGHT     = 4096;
    localparam int OP_QUEUE_DEPTH = 4;
    localparam logic [VOTE_W-1:0] VOTE_MAX = {VOTE_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_WINDOW_LEFT,
        CFG_WINDOW_TOP,
        CFG_WINDOW_RIGHT,
        CFG_WINDOW_BOTTOM
    } t_cfg_index;

    typedef enum logic {
        OP_COLUMN,
        OP_EMIT
    } t_op_kind;

    typedef enum logic [1:0] {
        PH_PIXEL,
        PH_ROW_END,
        PH_FLUSH,
        PH_EMIT
    } t_front_phase;

    typedef enum logic [1:0] {
        RS_IDLE,
        RS_SCAN,
        RS_SEND
    } t_report_state;

    typedef logic [PHASE_BINS-1:0][VOTE_W-1:0] t_bin_set;

    typedef struct packed {
        logic [WIN_COL_W-1:0] left;
        logic [WIN_ROW_W-1:0] top;
        logic [WIN_COL_W-1:0] right;
        logic [WIN_ROW_W-1:0] bottom;
    } t_window;

endpackage

FILE: sv/block_grid_vote_counter_unit.sv
// Grid phase vote counter: takes one 8-bit pixel per word in raster order and
// counts, per phase bin of eight, the strict local maxima of the 2x2 cross
// difference along rows and columns inside the configured window. After the last
// pixel of an image it returns eight words, one per bin, with the image totals,
// peaks and grid offsets. A pixel is taken every cycle unless the front end
// stalls, which it does to add an operation at the end of each row after the
// first, to pass over the final difference row and emit at the end of an image,
// and while the operation queue is full. The report scans the eight bins before
// its eight words appear, and the next image's report waits until the previous
// eight words are popped. Pixels keep flowing into the four-entry operation queue
// meanwhile, until it fills. Configuration should be written between images.
module block_grid_vote_counter_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [gvc_pkg::SAMPLE_W-1:0]      i_sample,
    output logic                              empty,
    input  logic                              pop,
    output logic [gvc_pkg::BIN_W-1:0]         o_bin_index,
    output logic [gvc_pkg::VOTE_W-1:0]        o_column_votes,
    output logic [gvc_pkg::VOTE_W-1:0]        o_row_votes,
    output logic [gvc_pkg::VOTE_W-1:0]        o_column_total,
    output logic [gvc_pkg::VOTE_W-1:0]        o_column_peak,
    output logic [gvc_pkg::BIN_W-1:0]         o_grid_x,
    output logic [gvc_pkg::VOTE_W-1:0]        o_row_total,
    output logic [gvc_pkg::VOTE_W-1:0]        o_row_peak,
    output logic [gvc_pkg::BIN_W-1:0]         o_grid_y,
    output logic                              o_last,
    input  logic                              i_cfg_we,
    input  logic [gvc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gvc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int OPW = 1 + XW + gvc_pkg::ROW_W + gvc_pkg::DIFF_W;

    logic [gvc_pkg::WIDTH_REG_W-1:0] r_image_width;
    logic [gvc_pkg::HEIGHT_W-1:0]    r_image_height;
    gvc_pkg::t_window                r_window;

    logic              op_push, op_full, op_pop, op_empty;
    logic [OPW-1:0]    op_in, op_out;
    logic              report_ready, report_start;
    gvc_pkg::t_bin_set col_bins, row_bins;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= 12'd2048;
            r_image_height  <= 13'd4096;
            r_window.left   <= 11'd0;
            r_window.top    <= 12'd0;
            r_window.right  <= 11'd2047;
            r_window.bottom <= 12'd4095;
        end else if (i_cfg_we) begin
            case (gvc_pkg::t_cfg_index'(i_cfg_index))
                gvc_pkg::CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data[11:0];
                gvc_pkg::CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data[12:0];
                gvc_pkg::CFG_WINDOW_LEFT:   r_window.left   <= i_cfg_data[10:0];
                gvc_pkg::CFG_WINDOW_TOP:    r_window.top    <= i_cfg_data[11:0];
                gvc_pkg::CFG_WINDOW_RIGHT:  r_window.right  <= i_cfg_data[10:0];
                gvc_pkg::CFG_WINDOW_BOTTOM: r_window.bottom <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    gvc_front #(
        .MAX_WIDTH(MAX_WIDTH),
        .XW(XW),
        .OPW(OPW)
    ) u_front (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(push),
        .o_full(full),
        .i_sample(i_sample),
        .i_image_width(r_image_width),
        .i_image_height(r_image_height),
        .o_op_valid(op_push),
        .o_op(op_in),
        .i_op_full(op_full)
    );

    gvc_fifo #(
        .WIDTH(OPW)
    ) u_queue (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_push(op_push),
        .i_data(op_in),
        .o_full(op_full),
        .i_pop(op_pop),
        .o_data(op_out),
        .o_empty(op_empty)
    );

    gvc_back #(
        .MAX_WIDTH(MAX_WIDTH),
        .XW(XW),
        .OPW(OPW)
    ) u_back (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_op_valid(!op_empty),
        .i_op(op_out),
        .o_op_pop(op_pop),
        .i_window(r_window),
        .i_report_ready(report_ready),
        .o_report_start(report_start),
        .o_col_bins(col_bins),
        .o_row_bins(row_bins)
    );

    gvc_report u_report (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(report_start),
        .i_col_bins(col_bins),
        .i_row_bins(row_bins),
        .o_ready(report_ready),
        .empty(empty),
        .pop(pop),
        .o_bin_index(o_bin_index),
        .o_column_votes(o_column_votes),
        .o_row_votes(o_row_votes),
        .o_column_total(o_column_total),
        .o_column_peak(o_column_peak),
        .o_grid_x(o_grid_x),
        .o_row_total(o_row_total),
        .o_row_peak(o_row_peak),
        .o_grid_y(o_grid_y),
        .o_last(o_last)
    );

endmodule

FILE: sv/gvc_fifo.sv
module gvc_fifo #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int DEPTH = gvc_pkg::OP_QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [PW:0]      r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: sv/gvc_front.sv
module gvc_front #(
    parameter int MAX_WIDTH = 2048,
    parameter int XW        = $clog2(MAX_WIDTH),
    parameter int OPW       = 1 + XW + gvc_pkg::ROW_W + gvc_pkg::DIFF_W
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    output logic                             o_full,
    input  logic [gvc_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic [gvc_pkg::WIDTH_REG_W-1:0]  i_image_width,
    input  logic [gvc_pkg::HEIGHT_W-1:0]     i_image_height,
    output logic                             o_op_valid,
    output logic [OPW-1:0]                   o_op,
    input  logic                             i_op_full
);
    localparam int RW = gvc_pkg::ROW_W;
    localparam int DW = gvc_pkg::DIFF_W;
    localparam int SW = gvc_pkg::SAMPLE_W;
    localparam int HW = gvc_pkg::HEIGHT_W;
    localparam int EW = (XW + 1 > gvc_pkg::WIDTH_REG_W) ? XW + 1 : gvc_pkg::WIDTH_REG_W;

    logic [SW-1:0] r_line [MAX_WIDTH];

    logic [XW-1:0] r_cnt_x;
    logic [RW-1:0] r_cnt_y;
    logic [SW-1:0] r_above;
    logic          r_s1_valid;
    logic [SW-1:0] r_s1_sample;
    logic [XW-1:0] r_s1_x;
    logic [RW-1:0] r_s1_y;
    logic          r_s1_xlast, r_s1_ylast;
    logic [SW-1:0] r_left, r_ul;
    logic [XW-1:0] r_fc, n_fc;
    gvc_pkg::t_front_phase r_phase, n_phase;

    logic [EW-1:0] iw_e, w_e;
    logic [XW:0]   w;
    logic [XW-1:0] wm1, x;
    logic [HW-1:0] h;
    logic [RW-1:0] hm1, y;
    logic          accept, done;
    logic signed [DW+1:0] t, t_abs;
    logic [DW-1:0] diff;
    gvc_pkg::t_op_kind op_kind;
    logic [XW-1:0] op_c;
    logic [RW-1:0] op_r;
    logic [DW-1:0] op_d;

    always_comb begin
        iw_e = EW'(i_image_width);
        if (iw_e < EW'(2)) begin
            w_e = EW'(2);
        end else if (iw_e > EW'(MAX_WIDTH)) begin
            w_e = EW'(MAX_WIDTH);
        end else begin
            w_e = iw_e;
        end
        w   = w_e[XW:0];
        wm1 = XW'(w - 1'b1);
        if (i_image_height < HW'(2)) begin
            h = HW'(2);
        end else if (i_image_height > HW'(gvc_pkg::MAX_HEIGHT)) begin
            h = HW'(gvc_pkg::MAX_HEIGHT);
        end else begin
            h = i_image_height;
        end
        hm1 = RW'(h - 1'b1);
        x   = ({1'b0, r_cnt_x} < w) ? r_cnt_x : wm1;
        y   = ({1'b0, r_cnt_y} < h) ? r_cnt_y : hm1;
    end

    always_comb begin
        t = $signed({3'b000, r_ul}) + $signed({3'b000, r_s1_sample})
          - $signed({3'b000, r_above}) - $signed({3'b000, r_left});
        t_abs = t[DW+1] ? -t : t;
        diff  = t_abs[DW-1:0];
    end

    always_comb begin
        n_phase    = r_phase;
        n_fc       = r_fc;
        o_op_valid = 1'b0;
        op_kind    = gvc_pkg::OP_COLUMN;
        op_c       = '0;
        op_r       = '0;
        op_d       = '0;
        done       = 1'b0;
        if (r_s1_valid) begin
            case (r_phase)
                gvc_pkg::PH_PIXEL: begin
                    o_op_valid = (r_s1_x != '0) && (r_s1_y != '0);
                    op_c = r_s1_x - 1'b1;
                    op_r = r_s1_y - 1'b1;
                    op_d = diff;
                    if (!o_op_valid || !i_op_full) begin
                        if (r_s1_xlast && (r_s1_y != '0)) begin
                            n_phase = gvc_pkg::PH_ROW_END;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
                gvc_pkg::PH_ROW_END: begin
                    o_op_valid = 1'b1;
                    op_c = r_s1_x;
                    op_r = r_s1_y - 1'b1;
                    if (!i_op_full) begin
                        if (r_s1_ylast) begin
                            n_phase = gvc_pkg::PH_FLUSH;
                            n_fc    = '0;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
                gvc_pkg::PH_FLUSH: begin
                    o_op_valid = 1'b1;
                    op_c = r_fc;
                    op_r = r_s1_y;
                    if (!i_op_full) begin
                        if (r_fc == r_s1_x) begin
                            n_phase = gvc_pkg::PH_EMIT;
                        end else begin
                            n_fc = r_fc + 1'b1;
                        end
                    end
                end
                gvc_pkg::PH_EMIT: begin
                    o_op_valid = 1'b1;
                    op_kind    = gvc_pkg::OP_EMIT;
                    if (!i_op_full) begin
                        done = 1'b1;
                    end
                end
                default: begin
                    done = 1'b1;
                end
            endcase
            if (done) begin
                n_phase = gvc_pkg::PH_PIXEL;
            end
        end
    end

    assign o_full = r_s1_valid && !done;
    assign accept = i_push && !o_full;
    assign o_op   = {op_kind, op_c, op_r, op_d};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_above   <= r_line[x];
            r_line[x] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_sample <= i_sample;
            r_s1_x      <= x;
            r_s1_y      <= y;
            r_s1_xlast  <= (x == wm1);
            r_s1_ylast  <= (y == hm1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= gvc_pkg::PH_PIXEL;
            r_fc       <= '0;
            r_s1_valid <= 1'b0;
            r_cnt_x    <= '0;
            r_cnt_y    <= '0;
            r_left     <= '0;
            r_ul       <= '0;
        end else begin
            r_phase    <= n_phase;
            r_fc       <= n_fc;
            r_s1_valid <= accept || (r_s1_valid && !done);
            if (done) begin
                r_left <= r_s1_sample;
                r_ul   <= r_above;
            end
            if (accept) begin
                if (x == wm1) begin
                    r_cnt_x <= '0;
                    r_cnt_y <= (y == hm1) ? '0 : y + 1'b1;
                end else begin
                    r_cnt_x <= x + 1'b1;
                end
            end
        end
    end

endmodule

FILE: sv/gvc_back.sv
module gvc_back #(
    parameter int MAX_WIDTH = 2048,
    parameter int XW        = $clog2(MAX_WIDTH),
    parameter int OPW       = 1 + XW + gvc_pkg::ROW_W + gvc_pkg::DIFF_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_op_valid,
    input  logic [OPW-1:0]    i_op,
    output logic              o_op_pop,
    input  gvc_pkg::t_window  i_window,
    input  logic              i_report_ready,
    output logic              o_report_start,
    output gvc_pkg::t_bin_set o_col_bins,
    output gvc_pkg::t_bin_set o_row_bins
);
    localparam int RW = gvc_pkg::ROW_W;
    localparam int DW = gvc_pkg::DIFF_W;
    localparam int BW = gvc_pkg::BIN_W;
    localparam int CW = (XW > gvc_pkg::WIN_COL_W) ? XW : gvc_pkg::WIN_COL_W;

    logic [2*DW-1:0] r_mem [MAX_WIDTH];
    logic [2*DW-1:0] r_rd;

    logic              r_b_valid;
    gvc_pkg::t_op_kind r_b_kind;
    logic [XW-1:0]     r_b_c;
    logic [RW-1:0]     r_b_r;
    logic [DW-1:0]     r_b_d;
    logic [DW-1:0]     r_tap1, r_tap2;
    gvc_pkg::t_bin_set r_col_bins, n_col_bins, r_row_bins, n_row_bins;

    logic [XW-1:0] in_c;
    logic          b_stall, wr, emit_fire, row_vote, col_vote;
    logic [DW-1:0] mid, up;
    logic [XW-1:0] cm1;
    logic [RW-1:0] rm1;
    logic [CW-1:0] c_e, cm1_e, wl_e, wr_e;
    logic          row_in_win, cur_col_in, prev_col_in;
    logic [BW-1:0] row_bin, col_bin;

    assign in_c      = i_op[OPW-2 -: XW];
    assign b_stall   = r_b_valid && (r_b_kind == gvc_pkg::OP_EMIT) && !i_report_ready;
    assign o_op_pop  = i_op_valid && !b_stall;
    assign wr        = r_b_valid && (r_b_kind == gvc_pkg::OP_COLUMN);
    assign emit_fire = r_b_valid && (r_b_kind == gvc_pkg::OP_EMIT) && i_report_ready;
    assign o_report_start = emit_fire;
    assign o_col_bins = r_col_bins;
    assign o_row_bins = r_row_bins;

    always_comb begin
        mid   = r_rd[2*DW-1:DW];
        up    = r_rd[DW-1:0];
        cm1   = r_b_c - 1'b1;
        rm1   = r_b_r - 1'b1;
        c_e   = CW'(r_b_c);
        cm1_e = CW'(cm1);
        wl_e  = CW'(i_window.left);
        wr_e  = CW'(i_window.right);
        row_in_win  = (rm1 >= i_window.top) && (rm1 <= i_window.bottom);
        cur_col_in  = (c_e >= wl_e) && (c_e <= wr_e);
        prev_col_in = (cm1_e >= wl_e) && (cm1_e <= wr_e);
        row_vote = wr && (r_b_r >= RW'(2)) && row_in_win && cur_col_in
                && (mid > up) && (mid > r_b_d);
        col_vote = wr && (r_b_r != '0) && (r_b_c >= XW'(2)) && row_in_win && prev_col_in
                && (r_tap1 > r_tap2) && (r_tap1 > mid);
        row_bin = rm1[BW-1:0];
        col_bin = cm1[BW-1:0];

        n_col_bins = r_col_bins;
        n_row_bins = r_row_bins;
        if (emit_fire) begin
            n_col_bins = '0;
            n_row_bins = '0;
        end else begin
            if (row_vote && (r_row_bins[row_bin] != gvc_pkg::VOTE_MAX)) begin
                n_row_bins[row_bin] = r_row_bins[row_bin] + 1'b1;
            end
            if (col_vote && (r_col_bins[col_bin] != gvc_pkg::VOTE_MAX)) begin
                n_col_bins[col_bin] = r_col_bins[col_bin] + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_op_pop) begin
            r_rd <= r_mem[in_c];
        end
        if (wr) begin
            r_mem[r_b_c] <= {r_b_d, mid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_op_pop) begin
            r_b_kind <= gvc_pkg::t_op_kind'(i_op[OPW-1]);
            r_b_c    <= in_c;
            r_b_r    <= i_op[RW+DW-1 -: RW];
            r_b_d    <= i_op[DW-1:0];
        end
        if (wr) begin
            r_tap2 <= r_tap1;
            r_tap1 <= mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_col_bins <= '0;
            r_row_bins <= '0;
        end else begin
            r_b_valid  <= o_op_pop || b_stall;
            r_col_bins <= n_col_bins;
            r_row_bins <= n_row_bins;
        end
    end

endmodule

FILE: sv/gvc_report.sv
module gvc_report (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  gvc_pkg::t_bin_set             i_col_bins,
    input  gvc_pkg::t_bin_set             i_row_bins,
    output logic                          o_ready,
    output logic                          empty,
    input  logic                          pop,
    output logic [gvc_pkg::BIN_W-1:0]     o_bin_index,
    output logic [gvc_pkg::VOTE_W-1:0]    o_column_votes,
    output logic [gvc_pkg::VOTE_W-1:0]    o_row_votes,
    output logic [gvc_pkg::VOTE_W-1:0]    o_column_total,
    output logic [gvc_pkg::VOTE_W-1:0]    o_column_peak,
    output logic [gvc_pkg::BIN_W-1:0]     o_grid_x,
    output logic [gvc_pkg::VOTE_W-1:0]    o_row_total,
    output logic [gvc_pkg::VOTE_W-1:0]    o_row_peak,
    output logic [gvc_pkg::BIN_W-1:0]     o_grid_y,
    output logic                          o_last
);
    localparam int VW = gvc_pkg::VOTE_W;
    localparam int BW = gvc_pkg::BIN_W;
    localparam logic [BW-1:0] LAST_BIN = BW'(gvc_pkg::PHASE_BINS - 1);

    gvc_pkg::t_report_state r_state, n_state;
    gvc_pkg::t_bin_set      r_col, r_row;
    logic [BW-1:0] r_idx, n_idx;
    logic [VW-1:0] r_nx, n_nx, r_kx, n_kx, r_ny, n_ny, r_ky, n_ky;
    logic [BW-1:0] r_gx, n_gx, r_gy, n_gy;
    logic [VW-1:0] col, row;
    logic [VW:0]   sx, sy;

    assign col = r_col[r_idx];
    assign row = r_row[r_idx];
    assign sx  = {1'b0, r_nx} + {1'b0, col};
    assign sy  = {1'b0, r_ny} + {1'b0, row};

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_nx = r_nx;
        n_kx = r_kx;
        n_gx = r_gx;
        n_ny = r_ny;
        n_ky = r_ky;
        n_gy = r_gy;
        case (r_state)
            gvc_pkg::RS_IDLE: begin
                if (i_start) begin
                    n_state = gvc_pkg::RS_SCAN;
                    n_idx = '0;
                    n_nx = '0;
                    n_kx = '0;
                    n_gx = '0;
                    n_ny = '0;
                    n_ky = '0;
                    n_gy = '0;
                end
            end
            gvc_pkg::RS_SCAN: begin
                n_nx = sx[VW] ? gvc_pkg::VOTE_MAX : sx[VW-1:0];
                n_ny = sy[VW] ? gvc_pkg::VOTE_MAX : sy[VW-1:0];
                if (col > r_kx) begin
                    n_kx = col;
                    n_gx = r_idx + 1'b1;
                end
                if (row > r_ky) begin
                    n_ky = row;
                    n_gy = r_idx + 1'b1;
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_BIN) begin
                    n_state = gvc_pkg::RS_SEND;
                end
            end
            gvc_pkg::RS_SEND: begin
                if (pop) begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == LAST_BIN) begin
                        n_state = gvc_pkg::RS_IDLE;
                    end
                end
            end
            default: begin
                n_state = gvc_pkg::RS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gvc_pkg::RS_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gvc_pkg::RS_IDLE && i_start) begin
            r_col <= i_col_bins;
            r_row <= i_row_bins;
        end
        r_nx <= n_nx;
        r_kx <= n_kx;
        r_gx <= n_gx;
        r_ny <= n_ny;
        r_ky <= n_ky;
        r_gy <= n_gy;
    end

    assign o_ready        = (r_state == gvc_pkg::RS_IDLE);
    assign empty          = (r_state != gvc_pkg::RS_SEND);
    assign o_bin_index    = r_idx;
    assign o_column_votes = col;
    assign o_row_votes    = row;
    assign o_column_total = r_nx;
    assign o_column_peak  = r_kx;
    assign o_grid_x       = r_gx;
    assign o_row_total    = r_ny;
    assign o_row_peak     = r_ky;
    assign o_grid_y       = r_gy;
    assign o_last         = (r_idx == LAST_BIN);

    a_start_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && o_ready) |=> (r_state == gvc_pkg::RS_SCAN && r_idx == '0))
        else $error("report did not start its scan at bin zero");

    a_scan_to_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gvc_pkg::RS_SCAN && r_idx == LAST_BIN)
        |=> (r_state == gvc_pkg::RS_SEND && r_idx == '0))
        else $error("report did not begin sending at bin zero after the scan");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_last) |=> (r_state == gvc_pkg::RS_IDLE))
        else $error("report kept sending after the last word");

    a_totals_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gvc_pkg::RS_SEND && $past(r_state) == gvc_pkg::RS_SEND)
        |-> ($stable(r_nx) && $stable(r_kx) && $stable(r_gx)))
        else $error("column summary changed while words were being sent");

endmodule

FILE: dv/block_grid_vote_counter_unit_test.sv
`timescale 1ns / 100ps

module block_grid_vote_counter_unit_test;

    localparam int LINE_LEN = 2048;
    localparam int CYCLE_LIMIT = 100000;
    localparam int BW = gvc_pkg::BIN_W;
    localparam int VW = gvc_pkg::VOTE_W;
    localparam int SW = gvc_pkg::SAMPLE_W;
    localparam int DW = gvc_pkg::DIFF_W;
    localparam int CDW = gvc_pkg::CFG_DATA_W;

    typedef struct packed {
        logic [BW-1:0] bin_index;
        logic [VW-1:0] column_votes;
        logic [VW-1:0] row_votes;
        logic [VW-1:0] column_total;
        logic [VW-1:0] column_peak;
        logic [BW-1:0] grid_x;
        logic [VW-1:0] row_total;
        logic [VW-1:0] row_peak;
        logic [BW-1:0] grid_y;
        logic          last;
    } t_vote_word;

    class t_vote_scoreboard;
        int unsigned width_reg, height_reg, win_left, win_top, win_right, win_bottom;
        logic [SW-1:0] pixel_row [LINE_LEN];
        logic [DW-1:0] diff_cur [LINE_LEN];
        logic [DW-1:0] diff_prev [LINE_LEN];
        int unsigned col_bins [gvc_pkg::PHASE_BINS];
        int unsigned row_bins [gvc_pkg::PHASE_BINS];
        int unsigned col_pos, row_pos;
        logic [SW-1:0] left_pix, upleft_pix;
        t_vote_word expected_words [$];
        int errors;

        function new();
            width_reg = 2048;
            height_reg = 4096;
            win_left = 0;
            win_top = 0;
            win_right = 2047;
            win_bottom = 4095;
            for (int i = 0; i < LINE_LEN; i++) begin
                pixel_row[i] = '0;
                diff_cur[i] = '0;
                diff_prev[i] = '0;
            end
            for (int i = 0; i < gvc_pkg::PHASE_BINS; i++) begin
                col_bins[i] = 0;
                row_bins[i] = 0;
            end
            col_pos = 0;
            row_pos = 0;
            left_pix = '0;
            upleft_pix = '0;
            errors = 0;
        endfunction

        function void write_reg(gvc_pkg::t_cfg_index idx, int unsigned value);
            case (idx)
                gvc_pkg::CFG_IMAGE_WIDTH:   width_reg = value & 32'hFFF;
                gvc_pkg::CFG_IMAGE_HEIGHT:  height_reg = value & 32'h1FFF;
                gvc_pkg::CFG_WINDOW_LEFT:   win_left = value & 32'h7FF;
                gvc_pkg::CFG_WINDOW_TOP:    win_top = value & 32'hFFF;
                gvc_pkg::CFG_WINDOW_RIGHT:  win_right = value & 32'h7FF;
                gvc_pkg::CFG_WINDOW_BOTTOM: win_bottom = value & 32'hFFF;
                default: ;
            endcase
        endfunction

        function bit in_win(int unsigned x, int unsigned y);
            return x >= win_left && x <= win_right && y >= win_top && y <= win_bottom;
        endfunction

        function void bump_col(int unsigned i);
            if (col_bins[i % gvc_pkg::PHASE_BINS] < gvc_pkg::VOTE_MAX)
                col_bins[i % gvc_pkg::PHASE_BINS]++;
        endfunction

        function void bump_row(int unsigned i);
            if (row_bins[i % gvc_pkg::PHASE_BINS] < gvc_pkg::VOTE_MAX)
                row_bins[i % gvc_pkg::PHASE_BINS]++;
        endfunction

        function void vote_column(int unsigned c, int unsigned r, logic [DW-1:0] dnew);
            logic [DW-1:0] up, mid, v;
            up = diff_prev[c];
            mid = diff_cur[c];
            if (r >= 2 && in_win(c, r - 1) && mid > up && mid > dnew) bump_row(r - 1);
            diff_prev[c] = mid;
            diff_cur[c] = dnew;
            if (r >= 1 && c >= 2) begin
                v = diff_prev[c - 1];
                if (in_win(c - 1, r - 1) && v > diff_prev[c - 2] && v > diff_prev[c])
                    bump_col(c - 1);
            end
        endfunction

        function void note_sample(logic [SW-1:0] s);
            int unsigned w, h, x, y, r;
            int t, ctot, cpk, cg, rtot, rpk, rg;
            t_vote_word word;
            w = width_reg < 2 ? 2 : (width_reg > LINE_LEN ? LINE_LEN : width_reg);
            h = height_reg < 2 ? 2 :
                (height_reg > gvc_pkg::MAX_HEIGHT ? gvc_pkg::MAX_HEIGHT : height_reg);
            x = col_pos < w ? col_pos : w - 1;
            y = row_pos < h ? row_pos : h - 1;
            if (x >= 1 && y >= 1) begin
                t = int'(upleft_pix) + int'(s) - int'(pixel_row[x]) - int'(left_pix);
                if (t < 0) t = -t;
                vote_column(x - 1, y - 1, t[DW-1:0]);
            end
            upleft_pix = pixel_row[x];
            pixel_row[x] = s;
            left_pix = s;
            if (x != w - 1) begin
                col_pos = x + 1;
                return;
            end
            if (y >= 1) vote_column(w - 1, y - 1, '0);
            col_pos = 0;
            if (y != h - 1) begin
                row_pos = y + 1;
                return;
            end
            // The bottom difference row is all zero, so the row before it is
            // voted on here, together with its column maxima.
            r = h - 2;
            for (int unsigned c = 0; c < w; c++)
                if (r >= 1 && in_win(c, r) && diff_cur[c] > diff_prev[c] && diff_cur[c] > 0)
                    bump_row(r);
            for (int unsigned c = 1; c + 1 < w; c++)
                if (in_win(c, r) && diff_cur[c] > diff_cur[c - 1] &&
                    diff_cur[c] > diff_cur[c + 1])
                    bump_col(c);
            row_pos = 0;
            ctot = 0; cpk = 0; cg = 0; rtot = 0; rpk = 0; rg = 0;
            for (int i = 0; i < gvc_pkg::PHASE_BINS; i++) begin
                ctot = ctot + col_bins[i] > gvc_pkg::VOTE_MAX ? gvc_pkg::VOTE_MAX :
                       ctot + col_bins[i];
                rtot = rtot + row_bins[i] > gvc_pkg::VOTE_MAX ? gvc_pkg::VOTE_MAX :
                       rtot + row_bins[i];
                if (col_bins[i] > cpk) begin
                    cpk = col_bins[i];
                    cg = (i + 1) % 8;
                end
                if (row_bins[i] > rpk) begin
                    rpk = row_bins[i];
                    rg = (i + 1) % 8;
                end
            end
            for (int i = 0; i < gvc_pkg::PHASE_BINS; i++) begin
                word.bin_index = BW'(i);
                word.column_votes = VW'(col_bins[i]);
                word.row_votes = VW'(row_bins[i]);
                word.column_total = VW'(ctot);
                word.column_peak = VW'(cpk);
                word.grid_x = BW'(cg);
                word.row_total = VW'(rtot);
                word.row_peak = VW'(rpk);
                word.grid_y = BW'(rg);
                word.last = (i == gvc_pkg::PHASE_BINS - 1);
                expected_words.push_back(word);
                col_bins[i] = 0;
                row_bins[i] = 0;
            end
        endfunction

        function void cmp_field(string name, int unsigned e, int unsigned a);
            if (e != a) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_word(t_vote_word got);
            t_vote_word e;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            cmp_field("bin_index", e.bin_index, got.bin_index);
            cmp_field("column_votes", e.column_votes, got.column_votes);
            cmp_field("row_votes", e.row_votes, got.row_votes);
            cmp_field("column_total", e.column_total, got.column_total);
            cmp_field("column_peak", e.column_peak, got.column_peak);
            cmp_field("grid_x", e.grid_x, got.grid_x);
            cmp_field("row_total", e.row_total, got.row_total);
            cmp_field("row_peak", e.row_peak, got.row_peak);
            cmp_field("grid_y", e.grid_y, got.grid_y);
            cmp_field("last", e.last, got.last);
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           push;
    logic                           full;
    logic [SW-1:0]                  i_sample;
    logic                           empty;
    logic                           pop;
    logic [BW-1:0]                  o_bin_index;
    logic [VW-1:0]                  o_column_votes;
    logic [VW-1:0]                  o_row_votes;
    logic [VW-1:0]                  o_column_total;
    logic [VW-1:0]                  o_column_peak;
    logic [BW-1:0]                  o_grid_x;
    logic [VW-1:0]                  o_row_total;
    logic [VW-1:0]                  o_row_peak;
    logic [BW-1:0]                  o_grid_y;
    logic                           o_last;
    logic                           i_cfg_we;
    logic [gvc_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [CDW-1:0]                 i_cfg_data;

    t_vote_scoreboard grid_votes = new();
    bit no_idle;
    int cycle_count = 0;
    int random_items;

    block_grid_vote_counter_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_sample      (i_sample),
        .empty         (empty),
        .pop           (pop),
        .o_bin_index   (o_bin_index),
        .o_column_votes(o_column_votes),
        .o_row_votes   (o_row_votes),
        .o_column_total(o_column_total),
        .o_column_peak (o_column_peak),
        .o_grid_x      (o_grid_x),
        .o_row_total   (o_row_total),
        .o_row_peak    (o_row_peak),
        .o_grid_y      (o_grid_y),
        .o_last        (o_last),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_sample = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = gvc_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data = '0;
        i_rst_n = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL block_grid_vote_counter_unit");
            $finish;
        end
    end

    // The result side pops at random and checks every word it takes.
    initial begin
        t_vote_word got;
        forever begin
            @(negedge i_clk);
            pop <= i_rst_n && (no_idle || $urandom_range(99) >= 21);
            @(posedge i_clk);
            if (pop && !empty) begin
                got = '{o_bin_index, o_column_votes, o_row_votes, o_column_total,
                        o_column_peak, o_grid_x, o_row_total, o_row_peak, o_grid_y, o_last};
                grid_votes.check_word(got);
            end
        end
    end

    task automatic write_reg(gvc_pkg::t_cfg_index idx, int unsigned value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CDW'(value);
        @(posedge i_clk);
        grid_votes.write_reg(idx, value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_sample(logic [SW-1:0] s);
        bit done;
        done = 0;
        while (!done) begin
            @(negedge i_clk);
            if (!no_idle && $urandom_range(99) < 21) begin
                push <= 1'b0;
                @(posedge i_clk);
            end else begin
                push <= 1'b1;
                i_sample <= s;
                @(posedge i_clk);
                if (!full) begin
                    grid_votes.note_sample(s);
                    done = 1;
                end
            end
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (grid_votes.expected_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Pattern 0 is random, 1 is a checkerboard of extremes, 2 is random extremes.
    task automatic run_images(int unsigned wreg, int unsigned hreg, int unsigned l,
                              int unsigned t, int unsigned r, int unsigned b,
                              int nimg, int pattern, bit pause_between);
        int unsigned w, h;
        logic [SW-1:0] s;
        write_reg(gvc_pkg::CFG_IMAGE_WIDTH, wreg);
        write_reg(gvc_pkg::CFG_IMAGE_HEIGHT, hreg);
        write_reg(gvc_pkg::CFG_WINDOW_LEFT, l);
        write_reg(gvc_pkg::CFG_WINDOW_TOP, t);
        write_reg(gvc_pkg::CFG_WINDOW_RIGHT, r);
        write_reg(gvc_pkg::CFG_WINDOW_BOTTOM, b);
        w = wreg < 2 ? 2 : (wreg > LINE_LEN ? LINE_LEN : wreg);
        h = hreg < 2 ? 2 : (hreg > gvc_pkg::MAX_HEIGHT ? gvc_pkg::MAX_HEIGHT : hreg);
        for (int n = 0; n < nimg; n++) begin
            for (int unsigned y = 0; y < h; y++) begin
                for (int unsigned x = 0; x < w; x++) begin
                    case (pattern)
                        1: s = ((x + y) % 2) ? 8'hFF : 8'h00;
                        2: s = $urandom_range(1) ? 8'hFF : 8'h00;
                        default: s = SW'(($urandom_range(3) == 0) ?
                                     ($urandom_range(1) ? 255 : 0) : $urandom_range(255));
                    endcase
                    send_sample(s);
                end
            end
            if (pause_between) drain();
        end
        drain();
    endtask

    initial begin
        int unsigned w, h, n;
        no_idle = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_images(4, 3, 0, 0, 2047, 4095, 1, 1, 0);
        run_images(1, 0, 0, 0, 2047, 4095, 1, 2, 0);
        run_images(6, 2, 0, 0, 2047, 4095, 1, 2, 0);
        run_images(5, 4, 20, 10, 30, 20, 1, 0, 0);
        run_images(5, 4, 3, 2, 1, 0, 1, 0, 0);
        run_images(2, 3, 2047, 4095, 2047, 4095, 1, 2, 0);
        run_images(9, 6, 2, 1, 5, 3, 3, 0, 1);

        // A long stretch with no idling on either side.
        no_idle = 1;
        run_images(12, 8, 0, 0, 2047, 4095, 1, 0, 0);
        no_idle = 0;

        random_items = 0;
        while (random_items < 70) begin
            w = $urandom_range(9) == 0 ? $urandom_range(1) : $urandom_range(12, 2);
            h = $urandom_range(8, 2);
            n = $urandom_range(3, 1);
            run_images(w, h, $urandom_range(5), $urandom_range(4), $urandom_range(14, 2),
                       $urandom_range(9, 1), int'(n), 0, 0);
            random_items += int'((w < 2 ? 2 : w) * h * n);
        end
        drain();

        if (grid_votes.errors == 0 && grid_votes.expected_words.size() == 0) begin
            $display("PASS block_grid_vote_counter_unit");
        end else begin
            $display("FAIL block_grid_vote_counter_unit");
        end
        $finish;
    end

endmodule

FILE: block_grid_vote_counter_unit.f
sv/gvc_pkg.sv
sv/gvc_fifo.sv
sv/gvc_front.sv
sv/gvc_back.sv
sv/gvc_report.sv
sv/block_grid_vote_counter_unit.sv
dv/block_grid_vote_counter_unit_test.sv
